/* src/sle_pkg.sv */
`timescale 1ns / 1ps
// Package for the sorted insertion list: operation and status codes,
// field widths and the default depth. No dependencies.
package sle_pkg;

  localparam int unsigned DepthDefault = 64;
  localparam int unsigned ValueW       = 32;
  localparam int unsigned IdxW         = 6;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

endpackage

/* src/sorted_list_engine_unit.sv */
`timescale 1ns / 1ps
// Sorted insertion list engine: a row of value cells kept in ascending order.
// Depends on sle_pkg for codes, widths and the default depth.
//
// One command is taken per cycle (busy stays low) and its result passes
// through the input registers and then the result registers to the result
// ports, where it is marked by done_o for one cycle; the receiver
// cannot stall and must take it then. The command is registered, every cell
// compares itself against the new value and shifts in the same cycle, and the
// result is registered, so the input and result registers lie between a
// command and its result and the rate is one command per cycle. Insert
// places a value in front of equal entries; read and remove check for an
// empty list first and then for an index at or beyond the count.
module sorted_list_engine_unit #(
  parameter int unsigned DEPTH = sle_pkg::DepthDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            func_i,
  input  logic signed [sle_pkg::ValueW-1:0]     value_i,
  input  logic [sle_pkg::IdxW-1:0]              index_i,
  output logic                                  done_o,
  output logic signed [sle_pkg::ValueW-1:0]     read_value_o,
  output logic [$clog2(DEPTH+1)-1:0]            count_o,
  output logic [1:0]                            status_o
);
  import sle_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CntW > IdxW) ? CntW : IdxW;

  logic                     vld_q;
  op_e                      op_q;
  logic signed [ValueW-1:0] val_q;
  logic [IdxW-1:0]          idx_q;

  logic signed [ValueW-1:0] cell_q [DEPTH];
  logic signed [ValueW-1:0] cell_d [DEPTH];
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [DEPTH-1:0]         lt;
  logic [DEPTH-1:0]         at_idx;
  logic [DEPTH-1:0]         from_idx;
  logic [CmpW-1:0]          idx_ext, cnt_ext;
  logic                     is_empty, idx_over, is_full;
  logic                     do_insert, do_remove, do_read;
  logic signed [ValueW-1:0] rd_mux, rd_d;
  status_e                  st_d;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      op_q  <= op_e'(func_i);
      val_q <= value_i;
      idx_q <= index_i;
    end
  end

  assign idx_ext  = CmpW'(idx_q);
  assign cnt_ext  = CmpW'(cnt_q);
  assign is_empty = (cnt_q == '0);
  assign idx_over = (idx_ext >= cnt_ext);
  assign is_full  = (cnt_q == CntW'(DEPTH));

  always_comb begin
    do_insert = 1'b0;
    do_remove = 1'b0;
    do_read   = 1'b0;
    st_d      = ST_OK;
    unique case (op_q)
      OP_INSERT: begin
        if (is_full) st_d = ST_FULL;
        else do_insert = vld_q;
      end
      OP_REMOVE, OP_READ: begin
        if (is_empty) st_d = ST_EMPTY;
        else if (idx_over) st_d = ST_RANGE;
        else if (op_q == OP_READ) do_read = vld_q;
        else do_remove = vld_q;
      end
      default: st_d = ST_OK;
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cmp
    assign lt[i]       = (CntW'(i) < cnt_q) && (cell_q[i] < val_q);
    assign at_idx[i]   = (CmpW'(i) == idx_ext);
    assign from_idx[i] = (CmpW'(i) >= idx_ext);
  end

  always_comb begin
    rd_mux = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_mux = rd_mux | (at_idx[i] ? cell_q[i] : '0);
    end
  end

  assign rd_d = do_read ? rd_mux : '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [ValueW-1:0] below, above;
    logic                     take_val;
    if (i == 0) begin : g_first
      assign below    = val_q;
      assign take_val = 1'b1;
    end else begin : g_rest
      assign below    = cell_q[i-1];
      assign take_val = lt[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign above = cell_q[i];
    end else begin : g_mid
      assign above = cell_q[i+1];
    end
    always_comb begin
      cell_d[i] = cell_q[i];
      if (do_insert && !lt[i]) begin
        cell_d[i] = take_val ? val_q : below;
      end else if (do_remove && from_idx[i]) begin
        cell_d[i] = above;
      end
    end
    always_ff @(posedge clk_i) begin
      cell_q[i] <= cell_d[i];
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (do_insert) cnt_d = cnt_q + CntW'(1);
    else if (do_remove) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_o <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q) begin
      read_value_o <= rd_d;
      count_o      <= cnt_d;
      status_o     <= st_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("entry count beyond depth");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |=> done_o)
    else $error("accepted command gave no result");

  a_full_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_FULL) |-> count_o == CntW'(DEPTH))
    else $error("full status with list not full");

  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_EMPTY) |-> count_o == '0)
    else $error("empty status with entries held");

  a_insert_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_insert |=> count_o == $past(cnt_q) + CntW'(1))
    else $error("insert did not grow the list by one");

endmodule

/* tb/sorted_list_engine_checker.sv */
`timescale 1ns / 1ps
// Checker for the sorted insertion list: watches command and result transfers,
// keeps its own ordered store and compares every result field by field.
// Depends on sle_pkg for operation and status codes and field widths.
module sorted_list_engine_checker #(
  parameter int unsigned DEPTH = sle_pkg::DepthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  input  logic                              busy,
  input  logic [1:0]                        func_i,
  input  logic signed [sle_pkg::ValueW-1:0] value_i,
  input  logic [sle_pkg::IdxW-1:0]          index_i,
  input  logic                              done_o,
  input  logic signed [sle_pkg::ValueW-1:0] read_value_o,
  input  logic [$clog2(DEPTH+1)-1:0]        count_o,
  input  logic [1:0]                        status_o,
  output int                                fail_count,
  output int                                pending
);

  import sle_pkg::*;

  localparam int unsigned CountW = $clog2(DEPTH + 1);

  typedef struct {
    logic signed [ValueW-1:0] read_value;
    logic [CountW-1:0]        count;
    status_e                  status;
  } list_result_t;

  logic signed [ValueW-1:0] cells [DEPTH];
  int                       held;
  list_result_t             expected_results [$];

  function automatic list_result_t apply_list_op(op_e op, logic signed [ValueW-1:0] val,
                                                 logic [IdxW-1:0] idx);
    list_result_t r;
    int           pos;
    int           i;
    r.read_value = '0;
    r.status     = ST_OK;
    case (op)
      OP_INSERT: begin
        if (held >= int'(DEPTH)) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < held && cells[pos] < val) pos++;
          for (i = held; i > pos; i--) cells[i] = cells[i-1];
          cells[pos] = val;
          held++;
        end
      end
      OP_REMOVE, OP_READ: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else if (int'(idx) >= held) begin
          r.status = ST_RANGE;
        end else if (op == OP_READ) begin
          r.read_value = cells[idx];
        end else begin
          for (i = int'(idx); i + 1 < held; i++) cells[i] = cells[i+1];
          held--;
        end
      end
      default: ;
    endcase
    r.count = CountW'(held);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    if (!rst_ni) begin
      held = 0;
      expected_results.delete();
      pending = 0;
    end else begin
      if (done_o) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no command waiting");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (read_value_o !== want.read_value) begin
            $error("read_value: expected %0d, actual %0d", want.read_value, read_value_o);
            fail_count++;
          end
          if (count_o !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, count_o);
            fail_count++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_o);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        expected_results.push_back(apply_list_op(op_e'(func_i), value_i, index_i));
      end
      pending = expected_results.size();
    end
  end

endmodule

/* tb/sorted_list_engine_unit_test.sv */
`timescale 1ns / 1ps
// Testbench top for the sorted insertion list: drives directed and random
// commands with idle bursts and gives the verdict. Depends on sle_pkg, the
// block and sorted_list_engine_checker.
module sorted_list_engine_unit_test;

  import sle_pkg::*;

  localparam int unsigned DEPTH       = DepthDefault;
  localparam int          StallLimit  = 500;
  localparam int          PhaseItems  = 100;
  localparam int          PhaseCount  = 14;
  localparam int          CalmPhases  = 2;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start;
  logic                       busy;
  op_e                        func;
  logic signed [ValueW-1:0]   value;
  logic [IdxW-1:0]            index;
  logic                       done_o;
  logic signed [ValueW-1:0]   read_value_o;
  logic [$clog2(DEPTH+1)-1:0] count_o;
  logic [1:0]                 status_o;
  int                         fail_count;
  int                         pending;
  int                         list_size;
  int                         stall_cycles;

  sorted_list_engine_unit #(.DEPTH(DEPTH)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (func),
    .value_i      (value),
    .index_i      (index),
    .done_o       (done_o),
    .read_value_o (read_value_o),
    .count_o      (count_o),
    .status_o     (status_o)
  );

  sorted_list_engine_checker #(.DEPTH(DEPTH)) list_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (func),
    .value_i      (value),
    .index_i      (index),
    .done_o       (done_o),
    .read_value_o (read_value_o),
    .count_o      (count_o),
    .status_o     (status_o),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic issue(op_e op, logic signed [ValueW-1:0] val, logic [IdxW-1:0] idx);
    start <= 1'b1;
    func  <= op;
    value <= val;
    index <= idx;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    case (op)
      OP_INSERT: if (list_size < int'(DEPTH)) list_size++;
      OP_REMOVE: if (list_size > 0 && int'(idx) < list_size) list_size--;
      default: ;
    endcase
  endtask

  task automatic hold_off(int cycles);
    start <= 1'b0;
    func  <= op_e'($urandom_range(0, 3));
    value <= $urandom;
    index <= IdxW'($urandom);
    repeat (cycles) @(posedge clk_i);
  endtask

  function automatic logic signed [ValueW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFFFFFF;
      1:       return 32'sh80000000;
      2, 3, 4: return $signed($urandom_range(0, 15)) - 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [IdxW-1:0] pick_index(int held);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70 && held > 0) return IdxW'($urandom_range(0, held - 1));
    if (r < 80 && held < (1 << IdxW)) return IdxW'(held);
    return IdxW'($urandom_range(0, (1 << IdxW) - 1));
  endfunction

  initial begin : stimulus
    int ins_pct [3];
    int rem_pct [3];
    int rd_pct  [3];
    int idle_pct;
    int kind;
    int r;
    int i;
    int phase;
    ins_pct = '{80, 10, 40};
    rem_pct = '{8, 75, 30};
    rd_pct  = '{9, 12, 27};
    list_size = 0;
    rst_ni <= 1'b0;
    start  <= 1'b0;
    func   <= OP_INSERT;
    value  <= '0;
    index  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    issue(OP_READ, '0, '0);
    issue(OP_REMOVE, '0, IdxW'(5));
    issue(OP_NONE, $urandom, IdxW'($urandom));
    issue(OP_INSERT, 32'sh7FFFFFFF, '0);
    issue(OP_INSERT, 32'sh80000000, '1);
    issue(OP_INSERT, 32'sd0, '0);
    issue(OP_INSERT, 32'sd0, '0);
    issue(OP_INSERT, -32'sd1, '0);
    issue(OP_INSERT, 32'sd1, '0);
    for (i = 0; i < 6; i++) issue(OP_READ, $urandom, IdxW'(i));
    issue(OP_READ, '0, IdxW'(6));
    issue(OP_READ, '0, '1);
    issue(OP_REMOVE, '0, IdxW'(5));
    issue(OP_REMOVE, '0, '0);
    issue(OP_REMOVE, '0, IdxW'(list_size));
    issue(OP_NONE, 32'sh7FFFFFFF, '1);
    issue(OP_READ, '0, '0);

    for (phase = 0; phase < PhaseCount; phase++) begin
      kind = phase % 3;
      if (phase >= PhaseCount - CalmPhases) idle_pct = 0;
      else idle_pct = (phase % 4 == 3) ? 0 : ((phase % 2 == 0) ? 10 : 25);
      for (i = 0; i < PhaseItems; i++) begin
        if ($urandom_range(0, 99) < idle_pct) hold_off($urandom_range(1, 9));
        r = $urandom_range(0, 99);
        if (r < ins_pct[kind]) begin
          issue(OP_INSERT, pick_value(), IdxW'($urandom));
        end else if (r < ins_pct[kind] + rem_pct[kind]) begin
          issue(OP_REMOVE, $urandom, pick_index(list_size));
        end else if (r < ins_pct[kind] + rem_pct[kind] + rd_pct[kind]) begin
          issue(OP_READ, $urandom, pick_index(list_size));
        end else begin
          issue(OP_NONE, $urandom, IdxW'($urandom));
        end
      end
    end

    start <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/sle_pkg.sv
src/sorted_list_engine_unit.sv
tb/sorted_list_engine_checker.sv
tb/sorted_list_engine_unit_test.sv
